>>> hw/rtl/wrbd_pkg.sv
// ----------------------------------------------------------------------------
// wrbd_pkg
// Shared types, register indexes and calendar helpers of the weekly reset
// boundary detector.
// ----------------------------------------------------------------------------
package wrbd_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEEKDAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR    = 2'd2;

    // input command codes
    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    typedef struct packed {
        logic                command;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
    } item_t;

    typedef struct packed {
        logic               enable;
        logic [WDAY_W-1:0]  weekday;
        logic [HOUR_W-1:0]  hour;
    } cfg_t;

    // what the calendar front end hands to the decision stage
    typedef struct packed {
        item_t              item;
        logic signed [5:0]  day_adj;   // day, minus one when before reset hour
        logic [2:0]         back;      // days back to the boundary weekday
        logic               leap;      // leap flag of the current year
    } bnd_t;

    // ((m + 1) * 26) / 10 for the shifted month 3..15
    function automatic logic [5:0] month_term(input logic [4:0] m);
        logic [5:0] t;
        unique case (m)
            5'd3:    t = 6'd10;
            5'd4:    t = 6'd13;
            5'd5:    t = 6'd15;
            5'd6:    t = 6'd18;
            5'd7:    t = 6'd20;
            5'd8:    t = 6'd23;
            5'd9:    t = 6'd26;
            5'd10:   t = 6'd28;
            5'd11:   t = 6'd31;
            5'd12:   t = 6'd33;
            5'd13:   t = 6'd36;
            5'd14:   t = 6'd39;
            5'd15:   t = 6'd41;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    // value mod 7 by folding octal digits (8 is 1 mod 7)
    function automatic logic [2:0] mod7(input logic [10:0] v);
        logic [4:0] f1;
        logic [3:0] f2;
        logic [2:0] r;
        f1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[10:9]);
        f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
        if (f2 >= 4'd7)
        begin
            r = 3'(f2 - 4'd7);
        end
        else
        begin
            r = f2[2:0];
        end
        return r;
    endfunction

    // length of a borrowed month; anything outside the short months is 31
    function automatic logic [4:0] month_days(input logic [4:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            5'd2:                     d = leap ? 5'd29 : 5'd28;
            5'd4, 5'd6, 5'd9, 5'd11:  d = 5'd30;
            default:                  d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/wrbd_front.sv
// ----------------------------------------------------------------------------
// wrbd_front
// Input register and calendar pipeline: weekday of the check day by Zeller's
// congruence and the number of days back to the boundary weekday.
// ----------------------------------------------------------------------------
module wrbd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  wrbd_pkg::cfg_t  cfg,
    input  logic            req_valid,
    output logic            req_stall,
    input  wrbd_pkg::item_t req_item,
    output logic            bnd_valid,
    input  logic            bnd_ready,
    output wrbd_pkg::bnd_t  bnd
);
    import wrbd_pkg::*;

    // stage 1: input register
    logic        v1_reg;
    item_t       s1_item_reg;
    // stage 2
    logic              v2_reg;
    item_t             s2_item_reg;
    logic signed [5:0] s2_day_reg;
    logic [YEAR_W-1:0] s2_yp_reg;
    logic [4:0]        s2_mp_reg;
    logic [7:0]        s2_hi_reg;
    // stage 3
    logic              v3_reg;
    item_t             s3_item_reg;
    logic signed [5:0] s3_day_reg;
    logic [10:0]       s3_sum_reg;
    logic              s3_leap_reg;

    logic ready1, ready2, ready3;

    logic              hr_below;
    logic signed [5:0] day_next;
    logic [YEAR_W-1:0] yp_next;
    logic [4:0]        mp_next;
    logic [26:0]       hi_prod;

    logic [14:0]  hi100;
    logic [14:0]  lo_full;
    logic [6:0]   lo;
    logic [11:0]  t1_prod;
    logic [9:0]   t2_prod;
    logic [12:0]  sum_full;
    logic         leap_next;

    logic [2:0]   wday;
    logic [2:0]   wd_cfg;

    assign ready3 = !v3_reg || bnd_ready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign req_stall = !ready1;

    // stage 1 logic: day step back, Zeller month shift, century by reciprocal
    always_comb
    begin
        hr_below = cfg.hour > s1_item_reg.hour;
        day_next = $signed({1'b0, s1_item_reg.day}) - $signed({5'd0, hr_below});
        if (s1_item_reg.month < 4'd3)
        begin
            yp_next = (s1_item_reg.year != '0) ? s1_item_reg.year - 14'd1 : '0;
            mp_next = {1'b0, s1_item_reg.month} + 5'd12;
        end
        else
        begin
            yp_next = s1_item_reg.year;
            mp_next = {1'b0, s1_item_reg.month};
        end
        // divide by 100: exact for any 14 bit year
        hi_prod = {13'd0, yp_next} * 27'd5243;
    end

    // stage 2 logic: year within century and the congruence sum
    always_comb
    begin
        hi100    = {7'd0, s2_hi_reg} * 15'd100;
        lo_full  = {1'b0, s2_yp_reg} - hi100;
        lo       = lo_full[6:0];
        t1_prod  = {4'd0, s2_hi_reg} * 12'd21;
        t2_prod  = {3'd0, lo} * 10'd5;
        sum_full = 13'(t1_prod[11:2]) + 13'(t2_prod[9:2]) + 13'(month_term(s2_mp_reg))
                 + {{7{s2_day_reg[5]}}, s2_day_reg} - 13'd1;
        // only used for a March check, where the shifted year is the year itself
        if (lo == 7'd0)
        begin
            leap_next = (s2_hi_reg[1:0] == 2'd0);
        end
        else
        begin
            leap_next = (s2_yp_reg[1:0] == 2'd0);
        end
    end

    // stage 3 logic: weekday and distance back to the boundary weekday
    always_comb
    begin
        wday   = mod7(s3_sum_reg);
        wd_cfg = (cfg.weekday == 3'd7) ? 3'd0 : cfg.weekday;
        bnd.item    = s3_item_reg;
        bnd.day_adj = s3_day_reg;
        bnd.leap    = s3_leap_reg;
        if (wday >= wd_cfg)
        begin
            bnd.back = wday - wd_cfg;
        end
        else
        begin
            bnd.back = 3'(4'(wday) + 4'd7 - 4'(wd_cfg));
        end
    end

    assign bnd_valid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= req_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && req_valid)
        begin
            s1_item_reg <= req_item;
        end
        if (ready2 && v1_reg)
        begin
            s2_item_reg <= s1_item_reg;
            s2_day_reg  <= day_next;
            s2_yp_reg   <= yp_next;
            s2_mp_reg   <= mp_next;
            s2_hi_reg   <= hi_prod[26:19];
        end
        if (ready3 && v2_reg)
        begin
            s3_item_reg <= s2_item_reg;
            s3_day_reg  <= s2_day_reg;
            s3_sum_reg  <= sum_full[10:0];
            s3_leap_reg <= leap_next;
        end
    end

endmodule

>>> hw/rtl/wrbd_judge.sv
// ----------------------------------------------------------------------------
// wrbd_judge
// Boundary date resolution with month and year borrow, comparison against
// the stored stamp, stamp and last-check state, and the result register.
// ----------------------------------------------------------------------------
module wrbd_judge
(
    input  logic            clk,
    input  logic            rst_n,
    input  wrbd_pkg::cfg_t  cfg,
    input  logic            bnd_valid,
    output logic            bnd_ready,
    input  wrbd_pkg::bnd_t  bnd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output logic            reset_due
);
    import wrbd_pkg::*;

    logic              v4_reg;
    bnd_t              s4_reg;
    logic              out_valid_reg;
    logic              reset_due_reg;

    logic [YEAR_W-1:0]  stamp_year_reg, stamp_year_next;
    logic [MONTH_W-1:0] stamp_month_reg, stamp_month_next;
    logic [DAY_W-1:0]   stamp_day_reg, stamp_day_next;
    logic [HOUR_W-1:0]  stamp_hour_reg, stamp_hour_next;
    logic [YEAR_W-1:0]  seen_year_reg, seen_year_next;
    logic [MONTH_W-1:0] seen_month_reg, seen_month_next;
    logic [DAY_W-1:0]   seen_day_reg, seen_day_next;
    logic [HOUR_W-1:0]  seen_hour_reg, seen_hour_next;

    logic              out_open;
    logic              adv;
    item_t             it;
    logic              same_hour;
    logic              active;
    logic signed [14:0] b_year;
    logic signed [4:0]  b_month;
    logic signed [5:0]  b_day;
    logic [5:0]         back_rem;
    logic [4:0]         mdays;
    logic signed [14:0] s_year;
    logic signed [4:0]  s_month;
    logic signed [5:0]  s_day;
    logic               earlier;
    logic               due;

    assign out_open  = !out_valid_reg || !rsp_stall;
    assign bnd_ready = !v4_reg || out_open;
    assign adv       = v4_reg && out_open;
    assign it        = s4_reg.item;

    always_comb
    begin
        same_hour = (seen_year_reg == it.year) && (seen_month_reg == it.month)
                 && (seen_day_reg == it.day) && (seen_hour_reg == it.hour);
        active    = (it.command == CMD_CHECK) && cfg.enable && !same_hour;

        back_rem = 6'({3'd0, s4_reg.back}) - s4_reg.day_adj;
        b_year   = $signed({1'b0, it.year});
        b_month  = $signed({1'b0, it.month});
        b_day    = s4_reg.day_adj - $signed({3'd0, s4_reg.back});
        mdays    = 5'd31;
        if (!(s4_reg.day_adj > $signed({3'd0, s4_reg.back})))
        begin
            // boundary falls in the previous month
            if (it.month == 4'd1)
            begin
                b_month = 5'sd12;
                b_year  = $signed({1'b0, it.year}) - 15'sd1;
            end
            else
            begin
                b_month = $signed({1'b0, it.month}) - 5'sd1;
            end
            mdays = month_days(b_month, s4_reg.leap);
            b_day = $signed({1'b0, mdays - back_rem[4:0]});
        end

        s_year  = $signed({1'b0, stamp_year_reg});
        s_month = $signed({1'b0, stamp_month_reg});
        s_day   = $signed({1'b0, stamp_day_reg});
        priority if (s_year != b_year)
        begin
            earlier = s_year < b_year;
        end
        else if (s_month != b_month)
        begin
            earlier = s_month < b_month;
        end
        else if (s_day != b_day)
        begin
            earlier = s_day < b_day;
        end
        else
        begin
            earlier = stamp_hour_reg < cfg.hour;
        end
        due = active && earlier;

        stamp_year_next  = stamp_year_reg;
        stamp_month_next = stamp_month_reg;
        stamp_day_next   = stamp_day_reg;
        stamp_hour_next  = stamp_hour_reg;
        seen_year_next   = seen_year_reg;
        seen_month_next  = seen_month_reg;
        seen_day_next    = seen_day_reg;
        seen_hour_next   = seen_hour_reg;
        if (adv)
        begin
            if ((it.command == CMD_LOAD) || due)
            begin
                stamp_year_next  = it.year;
                stamp_month_next = it.month;
                stamp_day_next   = it.day;
                stamp_hour_next  = it.hour;
            end
            if (active)
            begin
                seen_year_next  = it.year;
                seen_month_next = it.month;
                seen_day_next   = it.day;
                seen_hour_next  = it.hour;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            stamp_year_reg  <= 14'd2000;
            stamp_month_reg <= 4'd1;
            stamp_day_reg   <= 5'd1;
            stamp_hour_reg  <= '0;
            seen_year_reg   <= '0;
            seen_month_reg  <= '0;
            seen_day_reg    <= '0;
            seen_hour_reg   <= '0;
        end
        else
        begin
            if (bnd_ready)
            begin
                v4_reg <= bnd_valid;
            end
            if (out_open)
            begin
                out_valid_reg <= v4_reg;
            end
            stamp_year_reg  <= stamp_year_next;
            stamp_month_reg <= stamp_month_next;
            stamp_day_reg   <= stamp_day_next;
            stamp_hour_reg  <= stamp_hour_next;
            seen_year_reg   <= seen_year_next;
            seen_month_reg  <= seen_month_next;
            seen_day_reg    <= seen_day_next;
            seen_hour_reg   <= seen_hour_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bnd_ready && bnd_valid)
        begin
            s4_reg <= bnd;
        end
        if (adv)
        begin
            reset_due_reg <= due;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign reset_due = reset_due_reg;

    // a load word lands in the stamp
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && it.command == CMD_LOAD) |=>
            (stamp_year_reg == $past(it.year)) && (stamp_hour_reg == $past(it.hour)))
        else $error("stamp not loaded");

    // a reported boundary leaves stamp and last check on the same time
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && due) |=>
            (stamp_year_reg == seen_year_reg) && (stamp_month_reg == seen_month_reg)
            && (stamp_day_reg == seen_day_reg) && (stamp_hour_reg == seen_hour_reg))
        else $error("stamp and last check disagree after report");

    // a repeat of the last checked hour never reports
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && same_hour) |=> !reset_due_reg)
        else $error("repeat check reported a boundary");

    // load words never report
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && it.command == CMD_LOAD) |=> (rsp_valid && !reset_due))
        else $error("load word reported a boundary");

endmodule

>>> hw/rtl/weekly_reset_boundary_detector.sv
// ----------------------------------------------------------------------------
// weekly_reset_boundary_detector
// Flags a check time that lies past the latest weekly boundary after the
// stored stamp.
// ----------------------------------------------------------------------------
// Usage:
//   request channel (req_valid / req_stall): one word per check or stamp
//   load, fields command, year, month, day, hour. Taken when req_valid is
//   high and req_stall is low.
//   response channel (rsp_valid / rsp_stall): exactly one reset_due word per
//   request word, in order.
//   config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0
//   enable, 1 boundary weekday, 2 boundary hour. cfg_ready is always high;
//   write only while no request word is in flight.
// Pipeline: a taken word passes the input register, two calendar stages,
// the decision stage and the result register on its way to the response
// channel. One word per cycle is sustained while rsp_stall stays low;
// the stamp compare and update live in the single decision stage, so
// back-to-back checks see each other's state.
// Reset: pipeline empty, block disabled, stamp 2000-01-01 hour 0, last check
// all zero. A stalled response holds its word; the pipeline keeps filling
// and req_stall rises only once all stages are occupied.
// ----------------------------------------------------------------------------
module weekly_reset_boundary_detector
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic                             command,
    input  logic [wrbd_pkg::YEAR_W-1:0]      year,
    input  logic [wrbd_pkg::MONTH_W-1:0]     month,
    input  logic [wrbd_pkg::DAY_W-1:0]       day,
    input  logic [wrbd_pkg::HOUR_W-1:0]      hour,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic                             reset_due,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wrbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wrbd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wrbd_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    item_t req_item;
    logic  bnd_valid;
    logic  bnd_ready;
    bnd_t  bnd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            priority if (cfg_index == CFG_ENABLE)
            begin
                cfg_next.enable = cfg_data[0];
            end
            else if (cfg_index == CFG_WEEKDAY)
            begin
                cfg_next.weekday = cfg_data[WDAY_W-1:0];
            end
            else if (cfg_index == CFG_HOUR)
            begin
                cfg_next.hour = cfg_data[HOUR_W-1:0];
            end
            else
            begin
                cfg_next = cfg_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign req_item = '{command: command, year: year, month: month, day: day, hour: hour};

    wrbd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .bnd_valid (bnd_valid),
        .bnd_ready (bnd_ready),
        .bnd       (bnd)
    );

    wrbd_judge u_judge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .bnd_valid (bnd_valid),
        .bnd_ready (bnd_ready),
        .bnd       (bnd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .reset_due (reset_due)
    );

endmodule

>>> verif/wrbd_due_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrbd_due_checker
// Watches the request, response and config channels of the weekly reset
// boundary detector, predicts reset_due for every taken word and compares
// each response word against the oldest prediction.
// ----------------------------------------------------------------------------
module wrbd_due_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic                             req_stall,
    input  logic                             command,
    input  logic [wrbd_pkg::YEAR_W-1:0]      year,
    input  logic [wrbd_pkg::MONTH_W-1:0]     month,
    input  logic [wrbd_pkg::DAY_W-1:0]       day,
    input  logic [wrbd_pkg::HOUR_W-1:0]      hour,
    input  logic                             rsp_valid,
    input  logic                             rsp_stall,
    input  logic                             reset_due,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [wrbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wrbd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               errors,
    output int                               outstanding,
    output int                               words_taken,
    output int                               resets_expected
);

    import wrbd_pkg::*;

    // register copies
    logic               en_q;
    logic [WDAY_W-1:0]  wday_q;
    logic [HOUR_W-1:0]  rhour_q;

    // stored stamp and last checked time
    logic [YEAR_W-1:0]  stamp_y;
    logic [MONTH_W-1:0] stamp_m;
    logic [DAY_W-1:0]   stamp_d;
    logic [HOUR_W-1:0]  stamp_h;
    logic [YEAR_W-1:0]  seen_y;
    logic [MONTH_W-1:0] seen_m;
    logic [DAY_W-1:0]   seen_d;
    logic [HOUR_W-1:0]  seen_h;

    logic due_q[$];
    logic want;
    int   mismatch_count = 0;
    int   pending_count = 0;
    int   taken_count = 0;
    int   due_count = 0;

    assign errors          = mismatch_count;
    assign outstanding     = pending_count;
    assign words_taken     = taken_count;
    assign resets_expected = due_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    // zeller weekday, 0 is sunday; jan/feb count as months 13/14 of the year before
    function automatic int weekday_number(input int y, input int m, input int d);
        int cy;
        int cm;
        int total;
        cy = y;
        cm = m;
        if (cm < 3)
        begin
            cy = (cy > 0) ? cy - 1 : 0;
            cm = cm + 12;
        end
        total = -1 + ((cy / 100) * 21) / 4 + ((cy % 100) * 5) / 4 + d
                + ((cm + 1) * 26) / 10;
        if (total < 0)
            total = 0;
        return total % 7;
    endfunction

    function automatic bit leap_year(input int y);
        int a;
        a = (y < 0) ? -y : y;
        return (a % 400 == 0) || ((a % 4 == 0) && (a % 100 != 0));
    endfunction

    function automatic int month_length(input int y, input int m);
        int n;
        case (m)
            2:             n = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   n = 30;
            default:       n = 31;
        endcase
        return n;
    endfunction

    // applies one word to the state copy and returns the expected reset_due
    function automatic logic boundary_passed(input logic cmd,
                                             input logic [YEAR_W-1:0] yr,
                                             input logic [MONTH_W-1:0] mo,
                                             input logic [DAY_W-1:0] dy,
                                             input logic [HOUR_W-1:0] hr);
        int   by;
        int   bm;
        int   bd;
        int   bh;
        int   back;
        int   wd;
        int   sy;
        int   sm;
        int   sd;
        int   sh;
        logic earlier;
        if (cmd == CMD_LOAD)
        begin
            stamp_y = yr;
            stamp_m = mo;
            stamp_d = dy;
            stamp_h = hr;
            return 1'b0;
        end
        if (!en_q)
            return 1'b0;
        if (seen_y == yr && seen_m == mo && seen_d == dy && seen_h == hr)
            return 1'b0;
        seen_y = yr;
        seen_m = mo;
        seen_d = dy;
        seen_h = hr;

        by = yr;
        bm = mo;
        bd = dy;
        bh = rhour_q;
        if (rhour_q > hr)
            bd = bd - 1;
        wd = wday_q;
        back = (weekday_number(by, bm, bd) + 7 - wd % 7) % 7;
        if (bd > back)
            bd = bd - back;
        else
        begin
            // borrow from the previous month, day may go to zero or below first
            back = back - bd;
            if (bm == 1)
            begin
                bm = 12;
                by = by - 1;
            end
            else
                bm = bm - 1;
            bd = month_length(by, bm) - back;
        end

        sy = stamp_y;
        sm = stamp_m;
        sd = stamp_d;
        sh = stamp_h;
        if (sy != by)
            earlier = sy < by;
        else if (sm != bm)
            earlier = sm < bm;
        else if (sd != bd)
            earlier = sd < bd;
        else
            earlier = sh < bh;

        if (earlier)
        begin
            stamp_y = yr;
            stamp_m = mo;
            stamp_d = dy;
            stamp_h = hr;
        end
        return earlier;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_q    = 1'b0;
            wday_q  = '0;
            rhour_q = '0;
            stamp_y = YEAR_W'(2000);
            stamp_m = MONTH_W'(1);
            stamp_d = DAY_W'(1);
            stamp_h = '0;
            seen_y  = '0;
            seen_m  = '0;
            seen_d  = '0;
            seen_h  = '0;
            due_q.delete();
            pending_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENABLE:  en_q    = cfg_data[0];
                    CFG_WEEKDAY: wday_q  = cfg_data[WDAY_W-1:0];
                    CFG_HOUR:    rhour_q = cfg_data[HOUR_W-1:0];
                    default:     ;
                endcase
            end

            if (rsp_valid && !rsp_stall)
            begin
                if (due_q.size() == 0)
                    report_mismatch($sformatf("response word %b with nothing expected",
                                              reset_due));
                else
                begin
                    want = due_q.pop_front();
                    if (reset_due !== want)
                        report_mismatch($sformatf("reset_due got %b, expected %b",
                                                  reset_due, want));
                end
            end

            if (req_valid && !req_stall)
            begin
                want = boundary_passed(command, year, month, day, hour);
                due_q.push_back(want);
                taken_count++;
                if (want)
                    due_count++;
            end

            pending_count = due_q.size();
        end
    end

endmodule

>>> verif/weekly_reset_boundary_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weekly_reset_boundary_detector_tb
// Drives calendar checks and stamp loads into the weekly reset boundary
// detector under several register settings and idling patterns; the checker
// beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
module weekly_reset_boundary_detector_tb;

    import wrbd_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic                   command = CMD_CHECK;
    logic [YEAR_W-1:0]      year = '0;
    logic [MONTH_W-1:0]     month = '0;
    logic [DAY_W-1:0]       day = '0;
    logic [HOUR_W-1:0]      hour = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    logic                   reset_due;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int check_errors;
    int outstanding;
    int words_taken;
    int resets_expected;

    int idle_pct = 0;
    int stall_pct = 0;
    int settings = 0;

    // calendar walk used by the random part
    int    cur_y;
    int    cur_m;
    int    cur_d;
    int    cur_h;
    item_t last_check;
    int    special_years[8] = '{1, 2, 100, 400, 1900, 2000, 2100, 9999};

    weekly_reset_boundary_detector dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .command   (command),
        .year      (year),
        .month     (month),
        .day       (day),
        .hour      (hour),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .reset_due (reset_due),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wrbd_due_checker u_due_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .command         (command),
        .year            (year),
        .month           (month),
        .day             (day),
        .hour            (hour),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .reset_due       (reset_due),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .errors          (check_errors),
        .outstanding     (outstanding),
        .words_taken     (words_taken),
        .resets_expected (resets_expected)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    function automatic item_t mk_word(input logic c, input int y, input int m,
                                      input int d, input int h);
        item_t w;
        w.command = c;
        w.year    = y[YEAR_W-1:0];
        w.month   = m[MONTH_W-1:0];
        w.day     = d[DAY_W-1:0];
        w.hour    = h[HOUR_W-1:0];
        return w;
    endfunction

    function automatic int days_in_month(input int y, input int m);
        int n;
        case (m)
            2:           n = ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default:     n = 31;
        endcase
        return n;
    endfunction

    function automatic void walk_hours(input int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            cur_h++;
            if (cur_h == 24)
            begin
                cur_h = 0;
                cur_d++;
                if (cur_d > days_in_month(cur_y, cur_m))
                begin
                    cur_d = 1;
                    cur_m++;
                    if (cur_m == 13)
                    begin
                        cur_m = 1;
                        cur_y = (cur_y == 9999) ? 1 : cur_y + 1;
                    end
                end
            end
        end
    endfunction

    // mostly a forward walk through real dates, with loads, jumps and noise
    function automatic item_t next_word();
        int    pick;
        logic  use_cur;
        item_t w;
        pick = $urandom_range(99);
        use_cur = 1'b1;
        w = last_check;
        if (pick < 50)
            walk_hours($urandom_range(40));
        else if (pick < 58)
            walk_hours($urandom_range(100, 400));
        else if (pick < 78 && pick >= 68)
        begin
            cur_y = ($urandom_range(1) == 1) ? special_years[$urandom_range(7)]
                                             : $urandom_range(1, 9999);
            cur_m = ($urandom_range(1) == 1) ? $urandom_range(1, 3) : $urandom_range(1, 12);
            cur_d = ($urandom_range(1) == 1) ? 1
                                             : $urandom_range(1, days_in_month(cur_y, cur_m));
            cur_h = $urandom_range(23);
        end
        else
            use_cur = 1'b0;

        if (use_cur)
        begin
            w = mk_word(CMD_CHECK, cur_y, cur_m, cur_d, cur_h);
            last_check = w;
        end
        else if (pick < 68)
        begin
            if ($urandom_range(9) < 7)
                w = mk_word(CMD_LOAD, cur_y, cur_m, cur_d, $urandom_range(23));
            else
                w = mk_word(CMD_LOAD, $urandom_range(1, 9999), $urandom_range(1, 12),
                            $urandom_range(1, 28), $urandom_range(23));
        end
        else if (pick >= 84)
            w = mk_word($urandom_range(1), $urandom_range(16383), $urandom_range(15),
                        $urandom_range(31), $urandom_range(31));
        return w;
    endfunction

    task automatic send_word(input item_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        command   <= w.command;
        year      <= w.year;
        month     <= w.month;
        day       <= w.day;
        hour      <= w.hour;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // holds the sender until every expected word is back
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // unused upper data bits get random values
    task automatic set_config(input int en, input int wd, input int hr);
        write_reg(CFG_ENABLE, ($urandom_range(15) << 1) | (en & 1));
        write_reg(CFG_WEEKDAY, ($urandom_range(3) << 3) | (wd & 7));
        write_reg(CFG_HOUR, hr);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    initial
    begin
        int p;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // block still disabled out of reset
        idle_pct  = 25;
        stall_pct = 25;
        send_word(mk_word(CMD_CHECK, 2024, 3, 10, 5));
        send_word(mk_word(CMD_LOAD, 16383, 15, 31, 31));
        wait_idle();

        // weekday seven means sunday; hours below 23 step back a day
        set_config(1, 7, 23);
        send_word(mk_word(CMD_CHECK, 0, 0, 0, 0));
        send_word(mk_word(CMD_LOAD, 2000, 1, 1, 0));
        send_word(mk_word(CMD_CHECK, 2024, 3, 10, 5));
        send_word(mk_word(CMD_CHECK, 2024, 3, 10, 5));
        send_word(mk_word(CMD_CHECK, 2024, 3, 1, 0));
        send_word(mk_word(CMD_CHECK, 2100, 3, 1, 0));
        send_word(mk_word(CMD_CHECK, 2000, 3, 1, 2));
        send_word(mk_word(CMD_CHECK, 2023, 1, 1, 0));
        send_word(mk_word(CMD_CHECK, 1, 1, 1, 0));
        send_word(mk_word(CMD_LOAD, 0, 0, 0, 0));
        send_word(mk_word(CMD_CHECK, 0, 1, 1, 0));
        send_word(mk_word(CMD_CHECK, 0, 2, 0, 0));
        send_word(mk_word(CMD_CHECK, 5, 0, 0, 0));
        send_word(mk_word(CMD_CHECK, 9999, 13, 31, 23));
        send_word(mk_word(CMD_CHECK, 9999, 15, 31, 31));
        send_word(mk_word(CMD_CHECK, 16383, 14, 5, 7));
        send_word(mk_word(CMD_LOAD, 16383, 15, 31, 31));
        send_word(mk_word(CMD_CHECK, 16383, 15, 31, 30));
        send_word(mk_word(CMD_CHECK, 2024, 6, 31, 12));
        send_word(mk_word(CMD_LOAD, 2024, 6, 9, 0));
        send_word(mk_word(CMD_CHECK, 2024, 6, 16, 23));
        // stamp sitting exactly on the boundary
        send_word(mk_word(CMD_LOAD, 2024, 6, 30, 23));
        send_word(mk_word(CMD_CHECK, 2024, 6, 30, 23));

        for (p = 0; p < 8; p++)
        begin
            wait_idle();
            case (p)
                0:       set_config(1, 0, 0);
                1:       set_config(1, 6, 23);
                2:       set_config(1, 7, 31);
                3:       set_config(0, 3, 12);
                4:       set_config(1, $urandom_range(7), $urandom_range(24, 31));
                default: set_config(1, $urandom_range(7), $urandom_range(23));
            endcase
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 50;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 50;
                end
                default:
                begin
                    idle_pct  = 25;
                    stall_pct = 25;
                end
            endcase
            cur_y = $urandom_range(1, 9999);
            cur_m = $urandom_range(1, 12);
            cur_d = $urandom_range(1, 28);
            cur_h = $urandom_range(23);
            last_check = mk_word(CMD_CHECK, cur_y, cur_m, cur_d, cur_h);
            for (n = 0; n < 69; n++)
            begin
                if (p == 5 && n == 35)
                    wait_idle();
                send_word(next_word());
            end
        end

        wait_idle();
        stall_pct = 0;
        repeat (12) @(posedge clk);
        $display("covered %0d words over %0d register settings, %0d due a weekly reset",
                 words_taken, settings, resets_expected);
        $display("calendar edge cases, noise words and four idling patterns exercised");
        if (check_errors == 0)
            $display("weekly_reset_boundary_detector regression: pass");
        else
            $display("weekly_reset_boundary_detector regression: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d words outstanding", outstanding);
        $display("weekly_reset_boundary_detector regression: fail");
        $finish;
    end

endmodule
